// File: rtl/affine_vertex_normal_transform_defines.svh
// Assertion macros for the vertex and normal transform.
`ifndef AFFINE_VERTEX_NORMAL_TRANSFORM_DEFINES_SVH
`define AFFINE_VERTEX_NORMAL_TRANSFORM_DEFINES_SVH
// Implication checked on every clock edge outside reset.
`define AVNT_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication.
`define AVNT_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

// File: rtl/avnt_pkg.sv
// Package: types and constants for the vertex and normal transform.
`timescale 1ns / 1ps
package avnt_pkg;
    localparam int FRAC_BITS_DEF  = 16;
    localparam int WORD_WIDTH_DEF = 32;
    localparam int IO_W = 32;
    localparam int NUM_COEF = 12;

    localparam logic [1:0] CMD_LOAD   = 2'd0;
    localparam logic [1:0] CMD_VERTEX = 2'd1;
    localparam logic [1:0] CMD_BOTH   = 2'd2;
    localparam logic [1:0] CMD_SPARE  = 2'd3;   // undefined, acts as CMD_VERTEX

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_COF,
        ST_DET,
        ST_DIVSTART,
        ST_DIVWAIT,
        ST_VTX,
        ST_NRM,
        ST_OUT
    } t_state;

    // Operand index into the linear part, (r%3)*4+(c%3), for r and c up to 5
    function automatic logic [3:0] lin_idx(input logic [2:0] r, input logic [2:0] c);
        logic [2:0] rr;
        logic [2:0] cc;
        rr = (r >= 3'd3) ? r - 3'd3 : r;
        cc = (c >= 3'd3) ? c - 3'd3 : c;
        return {rr[1:0], 2'b00} + {2'b00, cc[1:0]};
    endfunction

    // Row and column of entry k of a row-major 3x3 matrix
    function automatic logic [1:0] row_of(input logic [3:0] k);
        return (k >= 4'd6) ? 2'd2 : ((k >= 4'd3) ? 2'd1 : 2'd0);
    endfunction

    function automatic logic [1:0] col_of(input logic [3:0] k);
        logic [3:0] rem;
        rem = k - 4'(row_of(k)) * 4'd3;
        return rem[1:0];
    endfunction
endpackage

// File: rtl/avnt_div.sv
// Restoring divider, one quotient bit per cycle, truncates toward zero.
`timescale 1ns / 1ps
module avnt_div import avnt_pkg::*; #(
    parameter int NW = 96,
    parameter int DW = 64
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic signed [NW-1:0] i_num,
    input  logic signed [DW-1:0] i_den,
    output logic                 o_done,
    output logic signed [NW-1:0] o_quo
);
    localparam int CW = $clog2(NW + 1);
    logic [NW-1:0] r_q;
    logic [DW:0]   r_rem;
    logic [DW-1:0] r_d;
    logic [CW-1:0] r_cnt;
    logic          r_busy;
    logic          r_neg;
    logic          r_done;
    logic [DW:0]   w_sh;
    logic [DW:0]   w_sub;

    assign w_sh  = {r_rem[DW-1:0], r_q[NW-1]};
    assign w_sub = w_sh - {1'b0, r_d};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(NW);
                r_q    <= i_num[NW-1] ? NW'(-i_num) : NW'(i_num);
                r_d    <= i_den[DW-1] ? DW'(-i_den) : DW'(i_den);
                r_neg  <= i_num[NW-1] ^ i_den[DW-1];
                r_rem  <= '0;
            end else if (r_busy) begin
                if (!w_sub[DW]) begin
                    r_rem <= w_sub;
                    r_q   <= {r_q[NW-2:0], 1'b1};
                end else begin
                    r_rem <= w_sh;
                    r_q   <= {r_q[NW-2:0], 1'b0};
                end
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_neg ? NW'(-r_q) : NW'(r_q);
endmodule

// File: rtl/affine_vertex_normal_transform.sv
// Top level: affine vertex and normal transform with one shared multiplier.
//
// Input channel i_valid/o_ready carries one command word: load a matrix
// coefficient, transform a vertex, or transform a vertex and a normal.
// Output channel o_valid/i_ready returns exactly one result word per
// command (all zero for a load). One word is in flight at a time.
//
// A load goes straight to its result word without using the multiplier.
// A transform runs one multiply-accumulate per cycle on one 33x32 signed
// multiplier; each phase drains its products before the next one starts.
// Vertex: 12 products (translation plus three per row). Vertex and
// normal: 9 more products. After a load to an index inside the matrix,
// the first transform rebuilds the normal matrix: 18 cofactor products,
// the determinant as 6 half-width products, then nine divisions (81
// quotient bits in a bit-serial divider), which are skipped if singular.
// Reset (synchronous, active low) restores the identity matrix and the
// identity normal matrix and clears both flags. When the receiver stalls,
// the result is held and no new word is taken until it is delivered.
`timescale 1ns / 1ps
`include "affine_vertex_normal_transform_defines.svh"
module affine_vertex_normal_transform import avnt_pkg::*; #(
    parameter int FRAC_BITS  = FRAC_BITS_DEF,
    parameter int WORD_WIDTH = WORD_WIDTH_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  logic [1:0]             i_command,
    input  logic [3:0]             i_coef_index,
    input  logic signed [IO_W-1:0] i_coef_value,
    input  logic signed [IO_W-1:0] i_vx,
    input  logic signed [IO_W-1:0] i_vy,
    input  logic signed [IO_W-1:0] i_vz,
    input  logic [IO_W-1:0]        i_vw,
    input  logic signed [IO_W-1:0] i_nx,
    input  logic signed [IO_W-1:0] i_ny,
    input  logic signed [IO_W-1:0] i_nz,
    input  logic [IO_W-1:0]        i_nw,
    output logic                   o_valid,
    input  logic                   i_ready,
    output logic signed [IO_W-1:0] o_px,
    output logic signed [IO_W-1:0] o_py,
    output logic signed [IO_W-1:0] o_pz,
    output logic [IO_W-1:0]        o_pw,
    output logic signed [IO_W-1:0] o_qx,
    output logic signed [IO_W-1:0] o_qy,
    output logic signed [IO_W-1:0] o_qz,
    output logic [IO_W-1:0]        o_qw,
    output logic                   o_singular,
    output logic                   o_overflow
);
    localparam int W   = WORD_WIDTH;
    localparam int F   = FRAC_BITS;
    localparam int CW  = 64;           // cofactor/det values kept in 64
    localparam int HW  = CW / 2;       // cofactor half fed to the multiplier
    localparam int MAW = W + 1;        // multiplier operand a, holds an unsigned half
    localparam int PW  = CW + W;       // aligned product width
    localparam int ACW = PW + 4;
    localparam int NW  = CW + F + 1;
    localparam logic signed [CW-1:0] S64_MAX = {1'b0, {(CW-1){1'b1}}};
    localparam logic signed [CW-1:0] S64_MIN = {1'b1, {(CW-1){1'b0}}};
    localparam logic signed [W-1:0]  WMAX = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0]  WMIN = {1'b1, {(W-1){1'b0}}};

    t_state r_st, n_st;
    logic signed [W-1:0]  r_a [NUM_COEF];
    logic signed [W-1:0]  r_n [9];
    logic signed [CW-1:0] r_cof [9];
    logic signed [CW-1:0] r_det;
    logic r_stale, r_sing;
    logic [1:0] r_cmd;
    logic signed [W-1:0] r_v [3];
    logic signed [W-1:0] r_nv [3];
    logic [IO_W-1:0] r_vw, r_nw;
    logic [4:0] r_step;            // product index within a phase
    logic signed [ACW-1:0] r_acc;
    logic signed [PW-1:0]  r_prod;
    logic r_pv;                    // r_prod valid
    logic r_plast;                 // last product of a sum
    logic [4:0] r_ptag;
    logic signed [W-1:0] r_res [6];
    logic r_ovf;
    logic r_ov;
    logic [3:0] r_didx;
    logic r_dstart;

    // multiplier operands
    logic signed [MAW-1:0] w_ma;
    logic signed [W-1:0]   w_mb;
    logic w_issue, w_last, w_neg, w_hi;
    logic [1:0] w_i, w_j;
    logic signed [CW-1:0]    w_dcof;
    logic signed [MAW+W-1:0] w_prod;
    logic signed [PW-1:0]    w_pext;

    // divider
    logic w_ddone;
    logic signed [NW-1:0] w_dq;
    logic signed [NW-1:0] w_dnum;

    assign w_dnum = NW'(r_cof[r_didx]) <<< F;

    avnt_div #(.NW(NW), .DW(CW)) u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(r_dstart),
        .i_num(w_dnum), .i_den(r_det), .o_done(w_ddone), .o_quo(w_dq)
    );

    assign w_dcof = r_cof[4'(r_step[2:1])];

    // operand select; a sum's terms are issued in r_step order
    always_comb begin
        w_ma = '0; w_mb = '0; w_issue = 1'b0; w_last = 1'b0; w_neg = 1'b0;
        w_hi = 1'b0;
        w_i = '0; w_j = '0;
        unique case (r_st)
            ST_COF: begin
                // step = cof*2 + term
                w_issue = r_step < 5'd18;
                w_i = row_of(r_step[4:1]);
                w_j = col_of(r_step[4:1]);
                if (!r_step[0]) begin
                    w_ma = MAW'(r_a[lin_idx(3'(w_i) + 3'd1, 3'(w_j) + 3'd1)]);
                    w_mb = r_a[lin_idx(3'(w_i) + 3'd2, 3'(w_j) + 3'd2)];
                end else begin
                    w_ma = MAW'(r_a[lin_idx(3'(w_i) + 3'd1, 3'(w_j) + 3'd2)]);
                    w_mb = r_a[lin_idx(3'(w_i) + 3'd2, 3'(w_j) + 3'd1)];
                    w_neg = 1'b1;
                    w_last = 1'b1;
                end
            end
            ST_DET: begin
                // step = column*2 + half; low half unsigned, high half signed
                w_issue = r_step < 5'd6;
                w_hi = r_step[0];
                if (r_step[0]) w_ma = MAW'($signed(w_dcof[CW-1:HW]));
                else           w_ma = MAW'({1'b0, w_dcof[HW-1:0]});
                w_mb = r_a[4'(r_step[2:1])];
                w_last = r_step == 5'd5;
            end
            ST_VTX: begin
                // per row: translation * 2^F, then three products
                w_issue = r_step < 5'd12;
                w_i = r_step[3:2];
                w_j = r_step[1:0];
                w_last = w_j == 2'd3;
                if (w_j == 2'd0) begin
                    w_ma = MAW'(r_a[{w_i, 2'd3}]);
                    w_mb = W'(1) <<< F;
                end else begin
                    w_ma = MAW'(r_a[{w_i, 2'd0} + {2'd0, w_j - 2'd1}]);
                    w_mb = r_v[w_j - 2'd1];
                end
            end
            ST_NRM: begin
                w_issue = r_step < 5'd9;
                w_i = row_of(r_step[3:0]);
                w_j = col_of(r_step[3:0]);
                w_last = w_j == 2'd2;
                w_ma = MAW'(r_n[4'(w_i) * 4'd3 + 4'(w_j)]);
                w_mb = r_nv[w_j];
            end
            default: ;
        endcase
    end

    assign w_prod = w_ma * w_mb;
    assign w_pext = w_neg ? -PW'(w_prod) : PW'(w_prod);

    // truncate-toward-zero shift and saturations
    logic signed [ACW-1:0] w_sum, w_shr;
    logic signed [CW-1:0]  w_s64;
    logic signed [W-1:0]   w_sw;
    logic w_sov;
    assign w_sum = r_acc + ACW'(r_prod);
    assign w_shr = w_sum[ACW-1] ? -((-w_sum) >>> F) : (w_sum >>> F);
    always_comb begin
        if (w_shr > ACW'(S64_MAX))      w_s64 = S64_MAX;
        else if (w_shr < ACW'(S64_MIN)) w_s64 = S64_MIN;
        else                            w_s64 = CW'(w_shr);
        w_sov = 1'b1;
        if (w_shr > ACW'(WMAX))      w_sw = WMAX;
        else if (w_shr < ACW'(WMIN)) w_sw = WMIN;
        else begin
            w_sw  = W'(w_shr);
            w_sov = 1'b0;
        end
    end
    logic signed [W-1:0] w_qsat;
    always_comb begin
        if (w_dq > NW'(WMAX))      w_qsat = WMAX;
        else if (w_dq < NW'(WMIN)) w_qsat = WMIN;
        else                       w_qsat = W'(w_dq);
    end

    logic w_pipe_empty;
    logic w_phase_done;
    logic w_det_zero;
    logic w_dstart;
    assign w_pipe_empty = !r_pv;
    assign w_phase_done = !w_issue && w_pipe_empty;
    assign w_det_zero   = r_det == '0;
    assign w_dstart = (r_st == ST_DET && w_phase_done && !w_det_zero) ||
                      (r_st == ST_DIVWAIT && w_ddone && r_didx != 4'd8);

    // next state
    always_comb begin
        n_st = r_st;
        unique case (r_st)
            ST_IDLE: if (i_valid) begin
                if (i_command == CMD_LOAD) n_st = ST_OUT;
                else if (r_stale)          n_st = ST_COF;
                else                       n_st = ST_VTX;
            end
            ST_COF: if (w_phase_done) n_st = ST_DET;
            ST_DET: if (w_phase_done) n_st = w_det_zero ? ST_VTX : ST_DIVSTART;
            ST_DIVSTART: n_st = ST_DIVWAIT;
            ST_DIVWAIT: if (w_ddone) n_st = (r_didx == 4'd8) ? ST_VTX : ST_DIVSTART;
            ST_VTX: if (w_phase_done)
                n_st = (r_cmd == CMD_BOTH) ? ST_NRM : ST_OUT;
            ST_NRM: if (w_phase_done) n_st = ST_OUT;
            ST_OUT: if (r_ov && i_ready) n_st = ST_IDLE;
            default: n_st = ST_IDLE;
        endcase
    end

    assign o_ready = r_st == ST_IDLE;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= ST_IDLE;
            r_stale <= 1'b0;
            r_sing <= 1'b0;
            r_pv <= 1'b0;
            r_ov <= 1'b0;
            r_dstart <= 1'b0;
            for (int k = 0; k < NUM_COEF; k++)
                r_a[k] <= (k % 5 == 0 && k < 11) ? (W'(1) <<< F) : '0;
            for (int k = 0; k < 9; k++)
                r_n[k] <= (k % 4 == 0) ? (W'(1) <<< F) : '0;
        end else begin
            r_st <= n_st;
            r_dstart <= w_dstart;
            // multiplier stage
            r_pv <= w_issue;
            r_plast <= w_last;
            r_ptag <= r_step;
            r_prod <= w_hi ? (w_pext <<< HW) : w_pext;
            if (r_st != n_st) r_step <= '0;
            else if (w_issue) r_step <= r_step + 5'd1;
            // accumulate stage
            if (r_pv) begin
                if (r_plast) begin
                    r_acc <= '0;
                    unique case (r_st)
                        ST_COF: r_cof[r_ptag[4:1]] <= w_s64;
                        ST_DET: r_det <= w_s64;
                        ST_VTX: begin
                            r_res[3'(r_ptag[3:2])] <= w_sw;
                            r_ovf <= r_ovf | w_sov;
                        end
                        ST_NRM: begin
                            r_res[3'd3 + 3'(row_of(r_ptag[3:0]))] <= w_sw;
                            r_ovf <= r_ovf | w_sov;
                        end
                        default: ;
                    endcase
                end else begin
                    r_acc <= w_sum;
                end
            end
            unique case (r_st)
                ST_IDLE: if (i_valid) begin
                    r_cmd <= (i_command == CMD_LOAD || i_command == CMD_BOTH) ?
                             i_command : CMD_VERTEX;
                    r_vw <= i_vw; r_nw <= i_nw;
                    r_v[0] <= i_vx; r_v[1] <= i_vy; r_v[2] <= i_vz;
                    r_nv[0] <= i_nx; r_nv[1] <= i_ny; r_nv[2] <= i_nz;
                    r_acc <= '0; r_ovf <= 1'b0; r_didx <= '0;
                    for (int k = 0; k < 6; k++) r_res[k] <= '0;
                    if (i_command == CMD_LOAD && i_coef_index < 4'(NUM_COEF)) begin
                        r_a[i_coef_index] <= W'(i_coef_value);
                        r_stale <= 1'b1;
                    end
                end
                ST_DET: if (w_phase_done) begin
                    r_sing <= w_det_zero;
                    r_stale <= 1'b0;
                    if (w_det_zero) for (int k = 0; k < 9; k++) r_n[k] <= '0;
                end
                ST_DIVWAIT: if (w_ddone) begin
                    r_n[r_didx] <= w_qsat;
                    if (r_didx != 4'd8) r_didx <= r_didx + 4'd1;
                end
                ST_OUT: begin
                    if (!r_ov) r_ov <= 1'b1;
                    else if (i_ready) r_ov <= 1'b0;
                end
                default: ;
            endcase
        end
    end

    // outputs
    always_comb begin
        o_valid = r_ov;
        o_px = IO_W'(r_res[0]); o_py = IO_W'(r_res[1]); o_pz = IO_W'(r_res[2]);
        o_qx = IO_W'(r_res[3]); o_qy = IO_W'(r_res[4]); o_qz = IO_W'(r_res[5]);
        o_pw = (r_cmd == CMD_LOAD) ? '0 : r_vw;
        o_qw = (r_cmd == CMD_BOTH) ? r_nw : '0;
        o_singular = (r_cmd == CMD_LOAD) ? 1'b0 : r_sing;
        o_overflow = r_ovf;
    end

    `AVNT_ASSERT_IMP(a_busy_not_ready, i_clk, i_rst_n, o_valid, !o_ready)
    `AVNT_ASSERT_NXT(a_out_held, i_clk, i_rst_n, o_valid && !i_ready, o_valid)
    `AVNT_ASSERT_IMP(a_load_zero, i_clk, i_rst_n, o_valid && r_cmd == CMD_LOAD,
        o_px == '0 && o_overflow == 1'b0)
endmodule

// File: sim/avnt_checker.sv
// Checker: watches both channels, predicts each result word and compares it.
`timescale 1ns / 1ps
module avnt_checker import avnt_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    input  logic                   o_ready,
    input  logic [1:0]             i_command,
    input  logic [3:0]             i_coef_index,
    input  logic signed [IO_W-1:0] i_coef_value,
    input  logic signed [IO_W-1:0] i_vx,
    input  logic signed [IO_W-1:0] i_vy,
    input  logic signed [IO_W-1:0] i_vz,
    input  logic [IO_W-1:0]        i_vw,
    input  logic signed [IO_W-1:0] i_nx,
    input  logic signed [IO_W-1:0] i_ny,
    input  logic signed [IO_W-1:0] i_nz,
    input  logic [IO_W-1:0]        i_nw,
    input  logic                   o_valid,
    input  logic                   i_ready,
    input  logic signed [IO_W-1:0] o_px,
    input  logic signed [IO_W-1:0] o_py,
    input  logic signed [IO_W-1:0] o_pz,
    input  logic [IO_W-1:0]        o_pw,
    input  logic signed [IO_W-1:0] o_qx,
    input  logic signed [IO_W-1:0] o_qy,
    input  logic signed [IO_W-1:0] o_qz,
    input  logic [IO_W-1:0]        o_qw,
    input  logic                   o_singular,
    input  logic                   o_overflow,
    output int                     o_fail_count,
    output int                     o_pending,
    output int                     o_singular_seen,
    output int                     o_overflow_seen
);
    localparam int F = FRAC_BITS_DEF;
    localparam int W = WORD_WIDTH_DEF;

    typedef logic signed [127:0] wide_t;

    typedef struct packed {
        logic [31:0] px, py, pz, pw, qx, qy, qz, qw;
        logic        sing, ovf;
    } xform_word_t;

    logic signed [63:0] mat[12];
    logic signed [63:0] inv_t[9];
    logic               inv_stale;
    logic               det_zero;
    xform_word_t        expected_q[$];

    function automatic wide_t shr_trunc(input wide_t a);
        return (a < 0) ? -((-a) >>> F) : (a >>> F);
    endfunction

    function automatic logic signed [63:0] clamp(input wide_t a, input int bits,
                                                  inout logic ovf);
        wide_t mx;
        wide_t mn;
        mx = (wide_t'(1) <<< (bits - 1)) - 1;
        mn = -mx - 1;
        if (a > mx) begin
            ovf = 1'b1;
            return mx[63:0];
        end
        if (a < mn) begin
            ovf = 1'b1;
            return mn[63:0];
        end
        return a[63:0];
    endfunction

    function automatic wide_t lin(input int r, input int c);
        return wide_t'(mat[(r % 3) * 4 + (c % 3)]);
    endfunction

    // Inverse-transpose of the linear part: cofactors over the determinant.
    task automatic rebuild_inverse();
        logic signed [63:0] cof[9];
        logic signed [63:0] det;
        wide_t              acc;
        logic               dummy;
        dummy = 1'b0;
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
                cof[i*3+j] = clamp(shr_trunc(lin(i+1, j+1) * lin(i+2, j+2)
                                             - lin(i+1, j+2) * lin(i+2, j+1)), 64, dummy);
        acc = 0;
        for (int j = 0; j < 3; j++)
            acc += lin(0, j) * wide_t'(cof[j]);
        det = clamp(shr_trunc(acc), 64, dummy);
        det_zero = (det == 0);
        for (int i = 0; i < 9; i++)
            inv_t[i] = det_zero ? 64'sd0
                     : clamp((wide_t'(cof[i]) <<< F) / wide_t'(det), W, dummy);
        inv_stale = 1'b0;
    endtask

    function automatic xform_word_t predict_word();
        xform_word_t r;
        wide_t       acc;
        wide_t       v[3];
        wide_t       n[3];
        logic        ovf;
        logic signed [63:0] s;
        r = '0;
        ovf = 1'b0;
        v[0] = i_vx; v[1] = i_vy; v[2] = i_vz;
        n[0] = i_nx; n[1] = i_ny; n[2] = i_nz;
        for (int i = 0; i < 3; i++) begin
            acc = wide_t'(mat[i*4+3]) <<< F;
            for (int j = 0; j < 3; j++) acc += wide_t'(mat[i*4+j]) * v[j];
            s = clamp(shr_trunc(acc), W, ovf);
            case (i)
                0: r.px = s[31:0];
                1: r.py = s[31:0];
                default: r.pz = s[31:0];
            endcase
        end
        r.pw = i_vw;
        if (i_command == CMD_BOTH) begin
            for (int i = 0; i < 3; i++) begin
                acc = 0;
                for (int j = 0; j < 3; j++) acc += wide_t'(inv_t[i*3+j]) * n[j];
                s = clamp(shr_trunc(acc), W, ovf);
                case (i)
                    0: r.qx = s[31:0];
                    1: r.qy = s[31:0];
                    default: r.qz = s[31:0];
                endcase
            end
            r.qw = i_nw;
        end
        r.sing = det_zero;
        r.ovf  = ovf;
        return r;
    endfunction

    xform_word_t got;
    xform_word_t exp_w;

    assign o_pending = expected_q.size();

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 12; i++) mat[i] = (i % 5 == 0) ? (64'sd1 <<< F) : 64'sd0;
            for (int i = 0; i < 9; i++) inv_t[i] = (i % 4 == 0) ? (64'sd1 <<< F) : 64'sd0;
            inv_stale = 1'b0;
            det_zero  = 1'b0;
            expected_q.delete();
            o_fail_count = 0;
            o_singular_seen = 0;
            o_overflow_seen = 0;
        end else begin
            if (o_valid && i_ready) begin
                got = '{o_px, o_py, o_pz, o_pw, o_qx, o_qy, o_qz, o_qw,
                        o_singular, o_overflow};
                if (got.sing) o_singular_seen++;
                if (got.ovf) o_overflow_seen++;
                if (expected_q.size() == 0) begin
                    o_fail_count++;
                    if (o_fail_count <= 10)
                        $display("%0t: result word with nothing expected: %h", $realtime, got);
                end else begin
                    exp_w = expected_q.pop_front();
                    if (got !== exp_w) begin
                        o_fail_count++;
                        if (o_fail_count <= 10) begin
                            $display("%0t: mismatch", $realtime);
                            $display("  exp p=%h %h %h %h q=%h %h %h %h sing=%b ovf=%b",
                                     exp_w.px, exp_w.py, exp_w.pz, exp_w.pw, exp_w.qx,
                                     exp_w.qy, exp_w.qz, exp_w.qw, exp_w.sing, exp_w.ovf);
                            $display("  got p=%h %h %h %h q=%h %h %h %h sing=%b ovf=%b",
                                     got.px, got.py, got.pz, got.pw, got.qx,
                                     got.qy, got.qz, got.qw, got.sing, got.ovf);
                        end
                    end
                end
            end
            if (i_valid && o_ready) begin
                if (i_command == CMD_LOAD) begin
                    if (i_coef_index < 4'd12) begin
                        mat[i_coef_index] = i_coef_value;
                        inv_stale = 1'b1;
                    end
                    expected_q.push_back('0);
                end else begin
                    if (inv_stale) rebuild_inverse();
                    expected_q.push_back(predict_word());
                end
            end
        end
    end
endmodule

// File: sim/tb_affine_vertex_normal_transform.sv
// Testbench top: stimulus, clock, reset, watchdog and verdict.
`timescale 1ns / 1ps
module tb_affine_vertex_normal_transform;
    import avnt_pkg::*;

    // A normal-matrix rebuild and receiver stalls both hold off the next word.
    localparam int IDLE_LIMIT = 20000;
    localparam int NUM_RANDOM = 1200;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_valid;
    logic                   o_ready;
    logic [1:0]             i_command;
    logic [3:0]             i_coef_index;
    logic signed [IO_W-1:0] i_coef_value;
    logic signed [IO_W-1:0] i_vx, i_vy, i_vz;
    logic [IO_W-1:0]        i_vw;
    logic signed [IO_W-1:0] i_nx, i_ny, i_nz;
    logic [IO_W-1:0]        i_nw;
    logic                   o_valid;
    logic                   i_ready;
    logic signed [IO_W-1:0] o_px, o_py, o_pz;
    logic [IO_W-1:0]        o_pw;
    logic signed [IO_W-1:0] o_qx, o_qy, o_qz;
    logic [IO_W-1:0]        o_qw;
    logic                   o_singular;
    logic                   o_overflow;

    int fail_count, pending, singular_seen, overflow_seen;
    int idle_cycles;
    int n_loads, n_vertex, n_both;

    affine_vertex_normal_transform DUT (.*);

    avnt_checker u_checker (
        .i_clk, .i_rst_n, .i_valid, .o_ready, .i_command, .i_coef_index,
        .i_coef_value, .i_vx, .i_vy, .i_vz, .i_vw, .i_nx, .i_ny, .i_nz, .i_nw,
        .o_valid, .i_ready, .o_px, .o_py, .o_pz, .o_pw, .o_qx, .o_qy, .o_qz,
        .o_qw, .o_singular, .o_overflow,
        .o_fail_count(fail_count), .o_pending(pending),
        .o_singular_seen(singular_seen), .o_overflow_seen(overflow_seen)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Mostly short gaps, now and then a long one.
    function automatic int gap_len();
        if ($urandom_range(0, 2) == 0) return 0;
        if ($urandom_range(0, 9) == 0) return $urandom_range(10, 40);
        return $urandom_range(0, 3);
    endfunction

    // Coefficients: mostly modest Q16.16 values, some integers, zeros, raw bits.
    function automatic logic [31:0] rand_coef();
        case ($urandom_range(0, 9))
            0:       return $urandom();
            1:       return 32'h0;
            2:       return ($urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000);
            3, 4:    return (32'($urandom_range(0, 6)) - 32'd3) << 16;
            default: return 32'($urandom_range(0, 32'h80000)) - 32'h40000;
        endcase
    endfunction

    function automatic logic [31:0] rand_comp();
        case ($urandom_range(0, 7))
            0:       return $urandom();
            1:       return ($urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000);
            default: return 32'($urandom_range(0, 32'h2000000)) - 32'h1000000;
        endcase
    endfunction

    // Drive one command word and hold it until the block takes it.
    task automatic send_word(input logic [1:0] cmd);
        i_command = cmd;
        i_valid   = 1'b1;
        case (cmd)
            CMD_LOAD:   n_loads++;
            CMD_BOTH:   n_both++;
            default:    n_vertex++;
        endcase
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        @(negedge i_clk);
        repeat (gap_len()) begin
            i_valid = 1'b0;
            @(negedge i_clk);
        end
    endtask

    task automatic load_coef(input logic [3:0] idx, input logic [31:0] val);
        i_coef_index = idx;
        i_coef_value = val;
        i_vx = $urandom(); i_vy = $urandom(); i_vz = $urandom(); i_vw = $urandom();
        i_nx = $urandom(); i_ny = $urandom(); i_nz = $urandom(); i_nw = $urandom();
        send_word(CMD_LOAD);
    endtask

    task automatic transform(input logic [1:0] cmd, input logic [31:0] x,
                             input logic [31:0] y, input logic [31:0] z);
        i_coef_index = $urandom();
        i_coef_value = $urandom();
        i_vx = x; i_vy = y; i_vz = z; i_vw = $urandom();
        i_nx = rand_comp(); i_ny = rand_comp(); i_nz = rand_comp(); i_nw = $urandom();
        send_word(cmd);
    endtask

    task automatic rand_transform();
        logic [1:0] cmd;
        cmd = ($urandom_range(0, 9) == 0) ? CMD_SPARE
            : ($urandom_range(0, 1) ? CMD_BOTH : CMD_VERTEX);
        transform(cmd, rand_comp(), rand_comp(), rand_comp());
    endtask

    // Receiver: bursts of ready between random stalls.
    initial begin
        i_ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            i_ready = 1'b1;
            repeat ($urandom_range(1, 20)) @(negedge i_clk);
            repeat (gap_len()) begin
                i_ready = 1'b0;
                @(negedge i_clk);
            end
        end
    end

    // Watchdog: cycles in a row with no word moving on either channel.
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) || !i_rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("FAIL affine_vertex_normal_transform");
            $finish;
        end
    end

    initial begin
        logic [31:0] row[3];
        int          sent;
        idle_cycles = 0;
        n_loads = 0; n_vertex = 0; n_both = 0;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_command = CMD_LOAD;
        i_coef_index = '0; i_coef_value = '0;
        i_vx = '0; i_vy = '0; i_vz = '0; i_vw = '0;
        i_nx = '0; i_ny = '0; i_nz = '0; i_nw = '0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: reset matrix with extreme vertices, then edge loads.
        transform(CMD_VERTEX, 32'h7fffffff, 32'h80000000, 32'h0);
        transform(CMD_BOTH, 32'h80000000, 32'h7fffffff, 32'hffffffff);
        transform(CMD_SPARE, 32'h00010000, 32'hffff0000, 32'h12345678);
        load_coef(4'd12, 32'h7fffffff);       // index past the matrix: ignored
        load_coef(4'd15, 32'h80000000);
        transform(CMD_BOTH, 32'h00020000, 32'h00030000, 32'h00040000);
        load_coef(4'd3, 32'h7fffffff);        // large translation
        transform(CMD_VERTEX, 32'h7fffffff, 32'h0, 32'h0);   // saturates
        load_coef(4'd0, 32'h00020000);
        load_coef(4'd10, 32'hfffe0000);
        transform(CMD_BOTH, 32'h00010000, 32'h00010000, 32'h00010000);
        load_coef(4'd5, 32'h0);               // zero diagonal: singular
        transform(CMD_BOTH, 32'h00010000, 32'h00020000, 32'h00030000);
        transform(CMD_SPARE, 32'h00010000, 32'h00020000, 32'h00030000);
        load_coef(4'd5, 32'h80000000);
        load_coef(4'd6, 32'h7fffffff);
        transform(CMD_BOTH, 32'h80000000, 32'h80000000, 32'h80000000);
        load_coef(4'd3, 32'h0);
        load_coef(4'd7, 32'h0);
        load_coef(4'd11, 32'h0);
        transform(CMD_BOTH, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff);

        // Random: matrix reloads followed by runs of transforms.
        sent = 0;
        while (sent < NUM_RANDOM) begin
            case ($urandom_range(0, 5))
                0: begin
                    // Duplicate row makes a singular linear part.
                    for (int j = 0; j < 3; j++) row[j] = rand_coef();
                    for (int j = 0; j < 3; j++) begin
                        load_coef(4'(j), row[j]);
                        load_coef(4'(4 + j), row[j]);
                    end
                    sent += 6;
                end
                1, 2: begin
                    repeat ($urandom_range(1, 4)) begin
                        load_coef(4'($urandom_range(0, 15)), rand_coef());
                        sent++;
                    end
                end
                default: begin
                    for (int k = 0; k < 12; k++) load_coef(4'(k), rand_coef());
                    sent += 12;
                end
            endcase
            repeat ($urandom_range(3, 14)) begin
                rand_transform();
                sent++;
            end
        end

        i_valid = 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (30) @(posedge i_clk);

        $display("Ran %0d loads, %0d vertex-only and %0d vertex+normal words.",
                 n_loads, n_vertex, n_both);
        $display("Results flagged singular: %0d, saturated: %0d.",
                 singular_seen, overflow_seen);
        if (fail_count == 0 && pending == 0)
            $display("PASS affine_vertex_normal_transform");
        else
            $display("FAIL affine_vertex_normal_transform");
        $finish;
    end
endmodule

// File: affine_vertex_normal_transform.f
+incdir+rtl
rtl/avnt_pkg.sv
rtl/avnt_div.sv
rtl/affine_vertex_normal_transform.sv
sim/avnt_checker.sv
sim/tb_affine_vertex_normal_transform.sv
